// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

  // Field widths of the request and result items
  localparam int KeyW   = 32;
  localparam int PrioW  = 8;
  localparam int CountW = 5;

  // Operation codes of a request
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  // Status codes of a result
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [KeyW-1:0]  key;
    logic [PrioW-1:0] priority_req;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [KeyW-1:0]   out_key;
    logic [PrioW-1:0]  out_priority;
    logic [CountW-1:0] count;
  } result_t;

  // Decoded command handed from the front end to the execution unit
  typedef struct packed {
    logic             is_insert;
    logic             is_pop;
    logic             is_scan;
    logic             drop_hit;
    logic [KeyW-1:0]  key;
    logic [PrioW-1:0] prio;
  } cmd_t;

endpackage

// ----- hw/rtl/spq_front.sv -----
module spq_front (
  input  logic           start,
  input  spq_pkg::req_t  req,
  input  logic           full,
  output logic           busy,
  output logic           push,
  output spq_pkg::cmd_t  cmd
);
  import spq_pkg::*;

  // Take a request whenever the command queue has room
  assign busy = full;
  assign push = start & ~full;

  // Decode the operation into the command flags of the execution unit
  always_comb begin
    cmd           = '0;
    cmd.key       = req.key;
    cmd.prio      = req.priority_req;
    unique case (req.op)
      OP_INSERT: begin
        cmd.is_insert = 1'b1;
      end
      OP_POP: begin
        cmd.is_pop = 1'b1;
      end
      OP_REMOVE: begin
        cmd.is_scan  = 1'b1;
        cmd.drop_hit = 1'b1;
      end
      OP_LOOKUP: begin
        cmd.is_scan = 1'b1;
      end
      default: begin
        cmd.is_scan = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/spq_cmd_fifo.sv -----
module spq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spq_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           valid,
  output spq_pkg::cmd_t  head_cmd,
  output logic           full
);
  import spq_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign valid    = (fill != 2'd0);
  assign full     = (fill == 2'd2);
  assign head_cmd = mem[rd_ptr];

  // Store an incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/spq_back.sv -----
module spq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  spq_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              strobe,
  output spq_pkg::result_t  result
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // Entry row, head at cell 0
  logic [KeyW-1:0]  key_q  [QUEUE_DEPTH];
  logic [PrioW-1:0] prio_q [QUEUE_DEPTH];

  logic [KeyW-1:0]  key_next  [QUEUE_DEPTH];
  logic [PrioW-1:0] prio_next [QUEUE_DEPTH];
  logic [KeyW-1:0]  key_up    [QUEUE_DEPTH];
  logic [PrioW-1:0] prio_up   [QUEUE_DEPTH];
  logic [KeyW-1:0]  key_dn    [QUEUE_DEPTH];
  logic [PrioW-1:0] prio_dn   [QUEUE_DEPTH];
  logic             ins       [QUEUE_DEPTH];
  logic             ins_dn    [QUEUE_DEPTH];

  state_t           state;
  logic [CW-1:0]    held;
  logic [CW-1:0]    held_next;
  logic [CW-1:0]    steps;
  logic             found;
  logic [KeyW-1:0]  cap_key;
  logic [PrioW-1:0] cap_prio;
  logic [KeyW-1:0]  scan_key;
  logic             scan_drop;

  logic             take;
  logic             do_ins;
  logic             do_pop;
  logic             head_hit;
  logic             do_drop;
  logic             shift_left;
  logic             do_rot;
  logic             res_load;
  result_t          res_next;
  logic [CW+CountW-1:0] cnt_wide;

  // Command decode for this cycle
  always_comb begin
    take       = (state == ST_IDLE) && cmd_valid;
    do_ins     = take && cmd.is_insert && (held != CW'(QUEUE_DEPTH));
    do_pop     = take && cmd.is_pop && (held != '0);
    head_hit   = (state == ST_SCAN) && !found && (key_q[0] == scan_key);
    do_drop    = head_hit && scan_drop;
    shift_left = do_pop || do_drop;
    do_rot     = (state == ST_SCAN) && !do_drop;
    held_next  = held;
    if (do_ins) begin
      held_next = held + CW'(1);
    end else if (shift_left) begin
      held_next = held - CW'(1);
    end
  end

  assign cmd_pop = take;

  // Neighbor taps of each cell
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign ins[i] = (CW'(i) >= held) || (prio_q[i] > cmd.prio);

    if (i == 0) begin : g_first
      assign key_dn[i]  = cmd.key;
      assign prio_dn[i] = cmd.prio;
      assign ins_dn[i]  = 1'b0;
    end else begin : g_mid_dn
      assign key_dn[i]  = key_q[i-1];
      assign prio_dn[i] = prio_q[i-1];
      assign ins_dn[i]  = ins[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign key_up[i]  = key_q[i];
      assign prio_up[i] = prio_q[i];
    end else begin : g_mid_up
      assign key_up[i]  = key_q[i+1];
      assign prio_up[i] = prio_q[i+1];
    end

    // Select the next content of this cell
    always_comb begin
      key_next[i]  = key_q[i];
      prio_next[i] = prio_q[i];
      if (do_ins && ins[i]) begin
        if (ins_dn[i]) begin
          key_next[i]  = key_dn[i];
          prio_next[i] = prio_dn[i];
        end else begin
          key_next[i]  = cmd.key;
          prio_next[i] = cmd.prio;
        end
      end else if (shift_left) begin
        key_next[i]  = key_up[i];
        prio_next[i] = prio_up[i];
      end else if (do_rot) begin
        if (held == CW'(i + 1)) begin
          key_next[i]  = key_q[0];
          prio_next[i] = prio_q[0];
        end else begin
          key_next[i]  = key_up[i];
          prio_next[i] = prio_up[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      key_q[i]  <= key_next[i];
      prio_q[i] <= prio_next[i];
    end
  end

  // Form the result of the finishing command
  always_comb begin
    cnt_wide              = {{CountW{1'b0}}, held_next};
    res_load              = 1'b0;
    res_next              = '0;
    res_next.status       = STAT_DONE;
    res_next.count        = cnt_wide[CountW-1:0];
    if (take) begin
      if (cmd.is_insert) begin
        res_load = 1'b1;
        if (!do_ins) begin
          res_next.status = STAT_FULL;
        end
      end else if (cmd.is_pop) begin
        res_load = 1'b1;
        if (do_pop) begin
          res_next.out_key      = key_q[0];
          res_next.out_priority = prio_q[0];
        end else begin
          res_next.status = STAT_MISS;
        end
      end else if (held == '0) begin
        res_load        = 1'b1;
        res_next.status = STAT_MISS;
      end
    end else if ((state == ST_SCAN) && (steps == CW'(1))) begin
      res_load = 1'b1;
      if (head_hit) begin
        res_next.out_key      = key_q[0];
        res_next.out_priority = prio_q[0];
      end else if (found) begin
        res_next.out_key      = cap_key;
        res_next.out_priority = cap_prio;
      end else begin
        res_next.status = STAT_MISS;
      end
    end
  end

  // Hold the result payload for its strobe cycle
  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

  // Hold the scan operands and the first hit
  always_ff @(posedge clk) begin
    if (take) begin
      scan_key  <= cmd.key;
      scan_drop <= cmd.drop_hit;
    end
    if (head_hit) begin
      cap_key  <= key_q[0];
      cap_prio <= prio_q[0];
    end
  end

  // Sequence commands: insert and pop finish in the idle state, scans take a full rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      held   <= '0;
      steps  <= '0;
      found  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      held   <= held_next;
      strobe <= res_load;
      unique case (state)
        ST_IDLE: begin
          if (take && cmd.is_scan && (held != '0)) begin
            state <= ST_SCAN;
            steps <= held;
            found <= 1'b0;
          end
        end
        ST_SCAN: begin
          steps <= steps - CW'(1);
          if (head_hit) begin
            found <= 1'b1;
          end
          if (steps == CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/stable_priority_queue.sv -----
// Bounded priority queue of (key, priority) entries, lowest priority value at
// the head, equal priorities kept in arrival order. A request transfers on a
// rising edge with start high and busy low; it enters a two-entry command
// queue and its result appears on result for exactly one cycle with strobe
// high, in request order. The receiver cannot stall: a result that is not
// taken in its strobe cycle is gone. Insert and pop finish as the execution
// unit takes them, so a stream of them transfers every cycle; the command
// queue and the strobe register lie between a transfer and its result.
// Remove and look up rotate the held entries through a full turn past the
// comparator at the head; busy rises while the command queue is full behind
// such a scan. Count reports the low five bits of the number of entries held.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::req_t     req,
  output logic              strobe,
  output spq_pkg::result_t  result
);
  import spq_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t head_cmd;

  // Accept and decode requests
  spq_front u_front (
    .start (start),
    .req   (req),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .cmd   (push_cmd)
  );

  // Buffer decoded commands between front end and execution
  spq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head_cmd (head_cmd),
    .full     (full)
  );

  // Execute commands on the entry row
  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
